FILE: design/dpb_pkg.sv
// Shared widths, register map and pipeline types for the depth back-projection block.
package dpb_pkg;

    // Field widths
    localparam int DEPTH_W = 16;
    localparam int PIX_W   = 12;
    localparam int FOC_W   = 16;
    localparam int CTR_W   = 18;
    localparam int MAXD_W  = 15;
    localparam int COORD_W = 24;
    localparam int Z_W     = 15;

    // Datapath widths
    localparam int OFS_W   = CTR_W + 1;                 // signed pixel offset, Q.6
    localparam int PROD_W  = (MAXD_W + 1) + OFS_W;      // signed depth * offset
    localparam int ABS_W   = MAXD_W + CTR_W;            // magnitude of the product
    localparam int MAG_W   = ABS_W + 4;                 // magnitude scaled to Q.4 result
    localparam int DIV_BITS = COORD_W;                  // quotient bits, one per stage
    localparam int HI_W    = MAG_W - DIV_BITS;
    localparam int CMP_W   = FOC_W + DIV_BITS;

    // Stage counts
    localparam int AXIS_LAT = DIV_BITS + 5;             // stages inside one axis
    localparam int LAT      = AXIS_LAT + 1;             // plus the input stage

    // Configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [FOC_W-1:0]  FOCAL_X_RST  = 16'd36864;
    localparam logic [FOC_W-1:0]  FOCAL_Y_RST  = 16'd36864;
    localparam logic [CTR_W-1:0]  CENTER_X_RST = 18'd20480;
    localparam logic [CTR_W-1:0]  CENTER_Y_RST = 18'd15360;
    localparam logic [MAXD_W-1:0] MAX_DEPTH_RST = 15'd1300;

    localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;

    typedef enum logic [2:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_MAX_DEPTH = 3'd4
    } t_reg_idx;

    // One step of the restoring divider
    typedef struct packed {
        logic [FOC_W-1:0]    rem;
        logic [DIV_BITS-1:0] lo;
        logic [DIV_BITS-1:0] quo;
        logic                neg;
        logic                ovf;
        logic                nz;
    } t_div;

endpackage

FILE: design/dpb_axis.sv
// One projection axis: offset, multiply, magnitude, pipelined division and saturation.
module dpb_axis
    import dpb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [MAXD_W-1:0]    i_depth,
    input  logic [PIX_W-1:0]     i_pix,
    input  logic [CTR_W-1:0]     i_center,
    input  logic [FOC_W-1:0]     i_focal,
    output logic [COORD_W-1:0]   o_coord
);

    logic        [MAXD_W-1:0]  r_a_d;
    logic signed [OFS_W-1:0]   r_a_ofs;
    logic signed [PROD_W-1:0]  r_b_prod;
    logic        [MAG_W-1:0]   r_c_mag;
    logic                      r_c_neg;
    t_div                      r_div [0:DIV_BITS];
    logic        [COORD_W-1:0] r_coord;

    logic [PROD_W-1:0]  n_abs;
    t_div               n_div0;
    t_div               n_div [1:DIV_BITS];
    logic [COORD_W-1:0] n_coord;

    function automatic t_div div_step(input t_div s, input logic [FOC_W-1:0] f);
        logic [FOC_W:0] t;
        logic           ge;
        t_div           o;
        t  = {s.rem, s.lo[DIV_BITS-1]};
        ge = (t >= {1'b0, f});
        o  = s;
        o.rem = ge ? FOC_W'(t - {1'b0, f}) : FOC_W'(t);
        o.lo  = {s.lo[DIV_BITS-2:0], 1'b0};
        o.quo = {s.quo[DIV_BITS-2:0], ge};
        return o;
    endfunction

    always_comb begin
        n_abs = r_b_prod[PROD_W-1] ? PROD_W'(-r_b_prod) : PROD_W'(r_b_prod);

        n_div0.rem = FOC_W'(r_c_mag[MAG_W-1:DIV_BITS]);
        n_div0.lo  = r_c_mag[DIV_BITS-1:0];
        n_div0.quo = '0;
        n_div0.neg = r_c_neg;
        n_div0.nz  = |r_c_mag;
        // quotient needs more than DIV_BITS bits, or focal length is zero
        n_div0.ovf = n_div0.nz &&
                     ({{(CMP_W-MAG_W){1'b0}}, r_c_mag} >= {i_focal, {DIV_BITS{1'b0}}});

        for (int k = 1; k <= DIV_BITS; k++) begin
            n_div[k] = div_step(r_div[k-1], i_focal);
        end
    end

    always_comb begin
        t_div s;
        s = r_div[DIV_BITS];
        if (!s.nz) begin
            n_coord = '0;
        end else if (!s.neg) begin
            n_coord = (s.ovf || s.quo > COORD_MAX) ? COORD_MAX : s.quo;
        end else begin
            n_coord = (s.ovf || s.quo > COORD_MIN) ? COORD_MIN : COORD_W'(-s.quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_d    <= i_depth;
            r_a_ofs  <= $signed({1'b0, i_pix, 6'b0}) - $signed({1'b0, i_center});
            r_b_prod <= $signed({1'b0, r_a_d}) * r_a_ofs;
            r_c_mag  <= {n_abs[ABS_W-1:0], 4'b0000};
            r_c_neg  <= r_b_prod[PROD_W-1];
            r_div[0] <= n_div0;
            for (int k = 1; k <= DIV_BITS; k++) begin
                r_div[k] <= n_div[k];
            end
            r_coord  <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

FILE: design/depth_pixel_backprojection.sv
// Top level of the pinhole depth-to-point back-projection pipeline.
//
// Usage:
//   Input stream (i_s_*): one depth pixel per transfer, tdata holds depth
//   [15:0] (signed mm), column [27:16] and row [39:28].
//   Output stream (o_m_*): one point per input transfer, in order. tdata holds
//   point_x [23:0] and point_y [47:24] (signed Q.4 mm, truncated toward zero,
//   saturated) and point_z [62:48]; tuser[0] is the valid flag. A pixel whose
//   depth is not strictly between zero and max_depth yields an all-zero point.
//   APB port: focal_x 0x00, focal_y 0x04, center_x 0x08, center_y 0x0C,
//   max_depth 0x10 (focal and center in unsigned Q.6). Write only while idle.
// Timing:
//   From input transfer to output valid a pixel passes one input stage,
//   offset, multiply, magnitude, range check, 24 divider stages (one
//   quotient bit each) and the saturating output register. Throughput is one
//   pixel per cycle while the output is not stalled.
//   The pipeline advances as a whole; when the output holds a point that is
//   not taken, every stage holds and o_s_tready drops, so nothing is lost or
//   repeated. Reset clears the valid bits and loads the register defaults.
module depth_pixel_backprojection
    import dpb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [39:0]       i_s_tdata,   // depth[15:0], column[27:16], row[39:28]

    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [63:0]       o_m_tdata,   // point_x[23:0], point_y[47:24], point_z[62:48]
    output logic [0:0]        o_m_tuser,   // valid_res[0]

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Configuration registers
    logic [FOC_W-1:0]  r_focal_x;
    logic [FOC_W-1:0]  r_focal_y;
    logic [CTR_W-1:0]  r_center_x;
    logic [CTR_W-1:0]  r_center_y;
    logic [MAXD_W-1:0] r_max_depth;

    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x   <= FOCAL_X_RST;
            r_focal_y   <= FOCAL_Y_RST;
            r_center_x  <= CENTER_X_RST;
            r_center_y  <= CENTER_Y_RST;
            r_max_depth <= MAX_DEPTH_RST;
        end else if (cfg_wr) begin
            case (paddr[APB_AW-1:2])
                REG_FOCAL_X:   r_focal_x   <= pwdata[FOC_W-1:0];
                REG_FOCAL_Y:   r_focal_y   <= pwdata[FOC_W-1:0];
                REG_CENTER_X:  r_center_x  <= pwdata[CTR_W-1:0];
                REG_CENTER_Y:  r_center_y  <= pwdata[CTR_W-1:0];
                REG_MAX_DEPTH: r_max_depth <= pwdata[MAXD_W-1:0];
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        case (paddr[APB_AW-1:2])
            REG_FOCAL_X:   prdata = APB_DW'(r_focal_x);
            REG_FOCAL_Y:   prdata = APB_DW'(r_focal_y);
            REG_CENTER_X:  prdata = APB_DW'(r_center_x);
            REG_CENTER_Y:  prdata = APB_DW'(r_center_y);
            REG_MAX_DEPTH: prdata = APB_DW'(r_max_depth);
            default:       prdata = '0;
        endcase
    end

    // Pipeline control: all stages move together, held by a stalled output
    logic [LAT-1:0] r_vld;
    logic           advance;

    assign advance    = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // Input stage: unpack, check the depth range, register
    logic [DEPTH_W-1:0] s_depth;
    logic [PIX_W-1:0]   s_col;
    logic [PIX_W-1:0]   s_row;
    logic               n_ok;

    assign s_depth = i_s_tdata[15:0];
    assign s_col   = i_s_tdata[27:16];
    assign s_row   = i_s_tdata[39:28];

    // strictly positive and below max_depth; the sign bit rules out negatives
    assign n_ok = !s_depth[DEPTH_W-1] && (|s_depth[DEPTH_W-2:0]) &&
                  (s_depth[DEPTH_W-2:0] < r_max_depth);

    logic [MAXD_W-1:0] r_s0_d;
    logic [PIX_W-1:0]  r_s0_col;
    logic [PIX_W-1:0]  r_s0_row;

    // Valid flag and gated depth ride alongside the axis pipelines
    logic              r_ok [0:LAT-1];
    logic [Z_W-1:0]    r_z  [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s0_d   <= s_depth[MAXD_W-1:0];
            r_s0_col <= s_col;
            r_s0_row <= s_row;
            r_ok[0]  <= n_ok;
            r_z[0]   <= n_ok ? s_depth[Z_W-1:0] : '0;
            for (int k = 1; k < LAT; k++) begin
                r_ok[k] <= r_ok[k-1];
                r_z[k]  <= r_z[k-1];
            end
        end
    end

    logic [COORD_W-1:0] ax_x;
    logic [COORD_W-1:0] ax_y;

    dpb_axis u_axis_x (
        .i_clk    (i_clk),
        .i_en     (advance),
        .i_depth  (r_s0_d),
        .i_pix    (r_s0_col),
        .i_center (r_center_x),
        .i_focal  (r_focal_x),
        .o_coord  (ax_x)
    );

    dpb_axis u_axis_y (
        .i_clk    (i_clk),
        .i_en     (advance),
        .i_depth  (r_s0_d),
        .i_pix    (r_s0_row),
        .i_center (r_center_y),
        .i_focal  (r_focal_y),
        .o_coord  (ax_y)
    );

    // Output: zero the coordinates of an out-of-range pixel
    logic out_ok;

    assign out_ok     = r_ok[LAT-1];
    assign o_m_tvalid = r_vld[LAT-1];
    assign o_m_tdata  = {1'b0, r_z[LAT-1],
                         out_ok ? ax_y : {COORD_W{1'b0}},
                         out_ok ? ax_x : {COORD_W{1'b0}}};
    assign o_m_tuser  = out_ok;

    // A stalled output must hold the whole pipeline, input included
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while output stalled");

    // An accepted pixel occupies the first stage on the next cycle
    a_accept_fills_s0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted pixel lost at input stage");

    // An invalid point carries no coordinates and no depth
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == 64'd0))
        else $error("invalid point with nonzero payload");

    // A valid point carries a depth inside the configured range
    a_valid_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |->
            ((o_m_tdata[62:48] != 15'd0) && (o_m_tdata[62:48] < r_max_depth)))
        else $error("valid point with out-of-range depth");

endmodule

FILE: verif/depth_pixel_backprojection_tb.sv
// Self-checking testbench for the depth pixel back-projection pipeline.
`timescale 1ns / 1ps

module depth_pixel_backprojection_tb
    import dpb_pkg::*;
;

    localparam longint COORD_HI   = 64'sd8388607;
    localparam longint COORD_LO   = -64'sd8388608;
    localparam longint TIMEOUT_NS = 5_000_000;
    localparam int     SCENE_PIXELS = 200;
    // Byte address past the last register; writes there must leave the camera untouched
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED = 5'h14;

    // One back-projected point as it leaves the block
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [Z_W-1:0]     z;
        logic               valid;
    } t_point;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [39:0]       i_s_tdata;   // depth[15:0], column[27:16], row[39:28]
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [63:0]       o_m_tdata;   // point_x[23:0], point_y[47:24], point_z[62:48]
    logic [0:0]        o_m_tuser;   // valid_res[0]
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Camera registers as the block should hold them
    logic [FOC_W-1:0]  cur_focal_x   = FOCAL_X_RST;
    logic [FOC_W-1:0]  cur_focal_y   = FOCAL_Y_RST;
    logic [CTR_W-1:0]  cur_center_x  = CENTER_X_RST;
    logic [CTR_W-1:0]  cur_center_y  = CENTER_Y_RST;
    logic [MAXD_W-1:0] cur_max_depth = MAX_DEPTH_RST;

    t_point      pending_points[$];
    int unsigned mismatch_count  = 0;
    int unsigned hold_off_cycles = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;

    depth_pixel_backprojection dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // One camera axis: offset in Q.6, scale the product to Q.4, divide by the
    // focal length truncating toward zero, then clamp to the 24-bit range.
    // A zero focal length pushes the coordinate to the limit on the side of
    // the numerator's sign, or to zero when the numerator is zero.
    function automatic logic [COORD_W-1:0] backproject_coord(input longint depth_mm,
                                                             input longint pix,
                                                             input longint center,
                                                             input longint focal);
        longint num;
        longint q;
        num = depth_mm * (pix * 64 - center) * 16;
        if (focal == 0) begin
            q = (num > 0) ? COORD_HI : (num < 0) ? COORD_LO : 0;
        end else begin
            q = num / focal;
            if (q > COORD_HI) q = COORD_HI;
            if (q < COORD_LO) q = COORD_LO;
        end
        return q[COORD_W-1:0];
    endfunction

    // Depth outside (0, max_depth) yields the all-zero point with the flag clear
    function automatic t_point project_point(input logic [39:0] word);
        t_point pt;
        longint depth_mm;
        depth_mm = longint'($signed(word[DEPTH_W-1:0]));
        pt = '0;
        if (depth_mm > 0 && depth_mm < longint'(cur_max_depth)) begin
            pt.x     = backproject_coord(depth_mm, longint'(word[27:16]),
                                         longint'(cur_center_x), longint'(cur_focal_x));
            pt.y     = backproject_coord(depth_mm, longint'(word[39:28]),
                                         longint'(cur_center_y), longint'(cur_focal_y));
            pt.z     = word[Z_W-1:0];
            pt.valid = 1'b1;
        end
        return pt;
    endfunction

    function automatic logic [APB_AW-1:0] reg_addr(input t_reg_idx idx);
        return {idx, 2'b00};
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Record the expected point on every input transfer, and match every
    // output transfer against the oldest one still waiting.
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                pending_points = {pending_points, project_point(i_s_tdata)};
            if (o_m_tvalid && i_m_tready) begin
                if (pending_points.size() == 0) begin
                    report_mismatch("point with no pixel behind it", o_m_tdata, '0);
                end else begin
                    want = pending_points.pop_front();
                    if (o_m_tdata[23:0] !== want.x)
                        report_mismatch("point_x", 64'(o_m_tdata[23:0]), 64'(want.x));
                    if (o_m_tdata[47:24] !== want.y)
                        report_mismatch("point_y", 64'(o_m_tdata[47:24]), 64'(want.y));
                    if (o_m_tdata[62:48] !== want.z)
                        report_mismatch("point_z", 64'(o_m_tdata[62:48]), 64'(want.z));
                    if (o_m_tuser[0] !== want.valid)
                        report_mismatch("valid_res", 64'(o_m_tuser[0]), 64'(want.valid));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: per point draw a wait, or serve a requested long hold-off
    // ------------------------------------------------------------------
    initial begin : point_sink
        int unsigned wait_n;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles != 0) begin
                wait_n = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                wait_n = rx_idle ? $urandom_range(0, 11) : 0;
            end
            if (wait_n != 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            // hold ready until one point transfers
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; every one starts and ends just after a falling edge
    // ------------------------------------------------------------------

    // Offer one pixel after a random gap and hold it until it transfers.
    // Valid stays high on return so back-to-back pixels need no extra edge.
    task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic [PIX_W-1:0] col,
                              input logic [PIX_W-1:0] row);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {row, col, depth};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted point has come out
    task automatic drain_points();
        i_s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(negedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the data at the edge
    // where psel, penable, pwrite and pready are all high. The task then idles
    // with psel low before it returns, so writes never run back to back.
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr[1:0] == 2'b00) begin
            case (addr[APB_AW-1:2])
                REG_FOCAL_X:   cur_focal_x   = data[FOC_W-1:0];
                REG_FOCAL_Y:   cur_focal_y   = data[FOC_W-1:0];
                REG_CENTER_X:  cur_center_x  = data[CTR_W-1:0];
                REG_CENTER_Y:  cur_center_y  = data[CTR_W-1:0];
                REG_MAX_DEPTH: cur_max_depth = data[MAXD_W-1:0];
                default: ;
            endcase
        end
        @(negedge i_clk);
    endtask

    task automatic set_camera(input logic [APB_DW-1:0] fx, input logic [APB_DW-1:0] fy,
                              input logic [APB_DW-1:0] cx, input logic [APB_DW-1:0] cy,
                              input logic [APB_DW-1:0] md);
        apb_write(reg_addr(REG_FOCAL_X), fx);
        apb_write(reg_addr(REG_FOCAL_Y), fy);
        apb_write(reg_addr(REG_CENTER_X), cx);
        apb_write(reg_addr(REG_CENTER_Y), cy);
        apb_write(reg_addr(REG_MAX_DEPTH), md);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset camera: depth sign and range edges, pixel range edges, principal point
    task automatic test_reset_camera();
        send_pixel(16'sd0, 12'd100, 12'd100);
        send_pixel(-16'sd1, 12'd100, 12'd100);
        send_pixel(16'h8000, 12'd4095, 12'd4095);
        send_pixel(16'h7FFF, 12'd0, 12'd0);
        send_pixel(16'sd1, 12'd0, 12'd0);
        send_pixel(16'sd1, 12'd4095, 12'd4095);
        send_pixel(16'sd1299, 12'd0, 12'd4095);
        send_pixel(16'sd1300, 12'd10, 12'd10);
        send_pixel(16'sd1301, 12'd10, 12'd10);
        send_pixel(16'sd500, 12'd320, 12'd240);
        send_pixel(16'sd777, 12'd319, 12'd241);
        send_pixel(16'sd1000, 12'd2048, 12'd1024);
        drain_points();
    endtask

    // Unit focal lengths drive both coordinates into the limits; the widest
    // focal length checks truncation toward zero of a negative quotient.
    task automatic test_saturation();
        set_camera(32'd1, 32'd1, 32'd0, 32'd262143, 32'd32767);
        send_pixel(16'sd32766, 12'd4095, 12'd0);
        send_pixel(16'sd32766, 12'd0, 12'd4095);
        drain_points();
        set_camera(32'd65535, 32'd65535, 32'd262143, 32'd0, 32'd32767);
        send_pixel(16'sd1, 12'd0, 12'd4095);
        send_pixel(16'sd32766, 12'd4095, 12'd0);
        drain_points();
    endtask

    // Zero focal length: the coordinate goes to the limit of its sign, or zero
    task automatic test_zero_focal();
        set_camera(32'd0, 32'd0, 32'd20480, 32'd15360, 32'd1300);
        send_pixel(16'sd100, 12'd400, 12'd100);
        send_pixel(16'sd100, 12'd320, 12'd240);
        send_pixel(16'sd1, 12'd0, 12'd4095);
        send_pixel(16'sd1299, 12'd4095, 12'd0);
        drain_points();
    endtask

    // Zero max depth rejects every pixel
    task automatic test_zero_max_depth();
        set_camera(32'd36864, 32'd36864, 32'd20480, 32'd15360, 32'd0);
        send_pixel(16'sd1, 12'd10, 12'd10);
        send_pixel(16'h7FFF, 12'd4095, 12'd4095);
        send_pixel(16'sd0, 12'd0, 12'd0);
        drain_points();
    endtask

    // A write past the register map must leave the camera as it was
    task automatic test_unmapped_write();
        set_camera(32'd36864, 32'd36864, 32'd20480, 32'd15360, 32'd1300);
        apb_write(ADDR_UNMAPPED, $urandom());
        send_pixel(16'sd800, 12'd600, 12'd30);
        send_pixel(16'sd1299, 12'd5, 12'd470);
        drain_points();
    endtask

    // Stall the output long enough to fill the pipeline while pixels keep
    // coming, then pause the input until everything is out, then go again.
    task automatic test_back_pressure();
        int i;
        tx_idle = 1'b0;
        hold_off_cycles = 120;
        for (i = 0; i < 40; i++)
            send_pixel(DEPTH_W'($urandom_range(1, 1299)), PIX_W'($urandom_range(0, 4095)),
                       PIX_W'($urandom_range(0, 4095)));
        drain_points();
        hold_off_cycles = 3 * LAT;
        for (i = 0; i < 40; i++)
            send_pixel(DEPTH_W'($urandom()), PIX_W'($urandom()), PIX_W'($urandom()));
        drain_points();
        tx_idle = 1'b1;
    endtask

    // Random scenes, each under its own camera and idling mix. Most depths are
    // in range so the divider sees real work; the rest cover every bit pattern.
    task automatic test_random_scenes();
        int scene;
        int i;
        logic [DEPTH_W-1:0] depth;
        logic [PIX_W-1:0]   col;
        for (scene = 0; scene < 6; scene++) begin
            tx_idle = (scene != 2) && (scene != 4);
            rx_idle = (scene != 2) && (scene != 5);
            case (scene)
                1: set_camera($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                3: set_camera($urandom_range(1, 64), $urandom_range(1, 64), $urandom(),
                              $urandom(), $urandom_range(0, 32767));
                5: set_camera(APB_DW'(FOCAL_X_RST), APB_DW'(FOCAL_Y_RST),
                              APB_DW'(CENTER_X_RST), APB_DW'(CENTER_Y_RST),
                              APB_DW'(MAX_DEPTH_RST));
                default: set_camera($urandom_range(300, 1000) << 6,
                                    $urandom_range(300, 1000) << 6,
                                    $urandom_range(0, 1280 << 6),
                                    $urandom_range(0, 960 << 6),
                                    $urandom_range(500, 32767));
            endcase
            for (i = 0; i < SCENE_PIXELS; i++) begin
                if ($urandom_range(0, 9) < 7 && cur_max_depth > 1)
                    depth = DEPTH_W'($urandom_range(1, cur_max_depth - 1));
                else
                    depth = DEPTH_W'($urandom());
                // now and then sit on the principal point column
                if ($urandom_range(0, 7) == 0)
                    col = cur_center_x[CTR_W-1:6];
                else
                    col = PIX_W'($urandom_range(0, 4095));
                send_pixel(depth, col, PIX_W'($urandom_range(0, 4095)));
            end
            drain_points();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_camera();
        test_saturation();
        test_zero_focal();
        test_zero_max_depth();
        test_unmapped_write();
        test_back_pressure();
        test_random_scenes();

        // let any stray point surface before the verdict
        repeat (LAT + 8) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here
    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
